### src/qfts_pkg.sv
`timescale 1ns / 1ps
package qfts_pkg;

	// Input item kinds
	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	// Result codes
	localparam logic [1:0] RC_OK    = 2'd0;
	localparam logic [1:0] RC_EMPTY = 2'd1;
	localparam logic [1:0] RC_FULL  = 2'd2;

	localparam int DATA_W = 32;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       push;      // write value on the input stack
		logic       xfer;      // one step of the input-to-output move
		logic       pop;       // read top of the output stack
		logic       load_res;  // load the result register
		logic       from_mem;  // result data comes from the output stack read
		logic [1:0] code;      // result code to load
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_full;
		logic in_empty;
		logic out_empty;
		logic xfer_done;
	} sts_t;

endpackage

### src/qfts_ram.sv
`timescale 1ns / 1ps
module qfts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/qfts_dp.sv
`timescale 1ns / 1ps
module qfts_dp #(
	parameter int DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  qfts_pkg::cmd_t      cmd,
	output qfts_pkg::sts_t      sts,
	input  logic signed [31:0]  value,
	output logic signed [31:0]  data_out,
	output logic [1:0]          result_code
);

	import qfts_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]     in_count_q;
	logic [CW-1:0]     out_count_q;
	logic              pend_q;
	logic [CW-1:0]     in_m1;
	logic [CW-1:0]     out_m1;
	logic              xfer_rd;
	logic [DATA_W-1:0] in_rdata;
	logic [DATA_W-1:0] out_rdata;
	logic [DATA_W-1:0] data_q;
	logic [1:0]        code_q;

	assign in_m1   = in_count_q - CW'(1);
	assign out_m1  = out_count_q - CW'(1);
	assign xfer_rd = cmd.xfer && (in_count_q != '0);

	qfts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_in_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (in_count_q[AW-1:0]),
		.wdata (value),
		.re    (xfer_rd),
		.raddr (in_m1[AW-1:0]),
		.rdata (in_rdata)
	);

	// write side of the move follows the read in the cycle after it
	qfts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_out_ram (
		.clk   (clk),
		.we    (pend_q),
		.waddr (out_count_q[AW-1:0]),
		.wdata (in_rdata),
		.re    (cmd.pop),
		.raddr (out_m1[AW-1:0]),
		.rdata (out_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= '0;
			out_count_q <= '0;
			pend_q      <= 1'b0;
		end else begin
			if (cmd.push) begin
				in_count_q <= in_count_q + CW'(1);
			end else if (xfer_rd) begin
				in_count_q <= in_m1;
			end
			pend_q <= xfer_rd;
			if (pend_q) begin
				out_count_q <= out_count_q + CW'(1);
			end else if (cmd.pop) begin
				out_count_q <= out_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			data_q <= cmd.from_mem ? out_rdata : '0;
			code_q <= cmd.code;
		end
	end

	assign sts.in_full   = (in_count_q == CW'(DEPTH));
	assign sts.in_empty  = (in_count_q == '0);
	assign sts.out_empty = (out_count_q == '0);
	assign sts.xfer_done = (in_count_q == '0) && !pend_q;

	assign data_out    = data_q;
	assign result_code = code_q;

`ifndef SYNTHESIS
	a_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_count_q <= CW'(DEPTH)) else $error("input stack count beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> in_count_q != CW'(DEPTH)) else $error("push on full input stack");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> out_count_q != '0) else $error("pop on empty output stack");
	a_pop_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !pend_q && in_count_q == '0 || !$past(cmd.xfer))
		else $error("pop before move finished");
`endif

endmodule

### src/qfts_ctrl.sv
`timescale 1ns / 1ps
module qfts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           mode,
	output logic           out_valid,
	input  logic           out_stall,
	output qfts_pkg::cmd_t cmd,
	input  qfts_pkg::sts_t sts
);

	import qfts_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_XFER = 3'd1;
	localparam logic [2:0] S_POP  = 3'd2;
	localparam logic [2:0] S_RESP = 3'd3;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] code_q;
	logic [1:0] code_d;
	logic       from_mem_q;
	logic       from_mem_d;
	logic       ovalid_q;
	logic       accept;
	logic       out_free;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !ovalid_q || !out_stall;

	always_comb begin
		state_d    = state_q;
		code_d     = code_q;
		from_mem_d = from_mem_q;
		cmd        = '0;
		cmd.code   = code_q;
		cmd.from_mem = from_mem_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d    = S_RESP;
					code_d     = RC_OK;
					from_mem_d = 1'b0;
					if (mode == MODE_ENQ) begin
						if (sts.in_full) begin
							code_d = RC_FULL;
						end else begin
							cmd.push = 1'b1;
						end
					end else if (!sts.out_empty) begin
						state_d    = S_POP;
						from_mem_d = 1'b1;
					end else if (!sts.in_empty) begin
						state_d    = S_XFER;
						from_mem_d = 1'b1;
					end else begin
						code_d = RC_EMPTY;
					end
				end
			end
			S_XFER: begin
				cmd.xfer = 1'b1;
				if (sts.xfer_done) begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			code_q     <= RC_OK;
			from_mem_q <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			code_q     <= code_d;
			from_mem_q <= from_mem_d;
			if (cmd.load_res) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;

endmodule

### src/queue_from_two_stacks_top.sv
`timescale 1ns / 1ps
// First-in first-out queue of signed 32-bit values built from two stacks of
// DEPTH entries, each held in a single-port-write RAM with registered read.
// Every input item gives one result. An enqueue is accepted, then loads the
// result register; an enqueue onto a full input stack is dropped with code 2.
// A dequeue with elements on the output stack goes through accept, pop read
// and result. A dequeue from an empty queue is accepted, then returns code 1
// with zero data. A dequeue that finds the output stack empty first moves all
// n input-stack entries across, one per cycle, and then does the pop. Each
// element crosses at most once. The move rate is set by the one read port of
// the input stack RAM and the one write port of the output stack RAM. After
// reset both stacks are empty; no clearing pass is needed.
module queue_from_two_stacks_top #(
	parameter int DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic signed [31:0] value,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] data_out,
	output logic [1:0]         result_code
);

	import qfts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequence each item: decide on accept, run the stack move, pop, and
	// hold the result until the output register is free.
	qfts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Stacks, their counts and the result register that parts the two
	// channels, so a new item is taken while a result waits for transfer.
	qfts_dp #(.DEPTH(DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (value),
		.data_out    (data_out),
		.result_code (result_code)
	);

endmodule
